### hw/rtl/cprpm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Capture period to rpm: shared package
// Field widths, word types, register indexes and reset values.
// ----------------------------------------------------------------------------
package cprpm_pkg;

	localparam int ClockW     = 29;
	localparam int PrescW     = 16;
	localparam int PeriodW    = 16;
	localparam int PprW       = 8;
	localparam int CountW     = 16;
	localparam int RpmW       = 32;
	localparam int IntervalW  = CountW + 1;
	localparam int PpW        = PrescW + PprW;
	localparam int DenW       = PpW + IntervalW;
	localparam int NumW       = ClockW + 10;
	localparam int CfgIdxW    = 2;
	localparam int CfgDataW   = ClockW;

	localparam int CountBitsDefault = 16;

	localparam logic [ClockW-1:0]  ClockHzReset   = ClockW'(84000000);
	localparam logic [PrescW-1:0]  PrescReset     = PrescW'(1);
	localparam logic [PeriodW-1:0] PeriodReset    = PeriodW'(65535);
	localparam logic [PprW-1:0]    PprReset       = PprW'(12);
	localparam logic [RpmW-1:0]    RpmMax         = '1;

	typedef enum logic [CfgIdxW-1:0] {
		REG_CLOCK_HZ       = 2'd0,
		REG_PRESCALER      = 2'd1,
		REG_TIMER_PERIOD   = 2'd2,
		REG_PULSES_PER_REV = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic              from_tach_channel;
		logic [CountW-1:0] captured_count;
	} capture_word_t;

	typedef struct packed {
		logic            measurement_done;
		logic [RpmW-1:0] rpm_x16;
	} speed_word_t;

endpackage
`default_nettype wire

### hw/rtl/cprpm_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Capture period to rpm: stream interface
// Valid/ready channel that carries one word per handshake.
// ----------------------------------------------------------------------------
interface cprpm_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### hw/rtl/cprpm_serial_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Capture period to rpm: bit-serial multiplier
// Shift-add multiplier that retires one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module cprpm_serial_mul #(
	parameter int AW = 24,
	parameter int BW = 17
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [AW-1:0]   a,
	input  wire logic [BW-1:0]   b,
	output logic                 done,
	output logic [AW+BW-1:0]     product
);

	localparam int CntW = (BW > 1) ? $clog2(BW) : 1;

	logic [AW-1:0]    a_q;
	logic [AW+BW-1:0] prod_q;
	logic [CntW-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [AW:0]      sum;

	assign sum = {1'b0, prod_q[AW+BW-1:BW]} + (prod_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CntW'(BW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			prod_q <= {{AW{1'b0}}, b};
		end else if (busy_q) begin
			prod_q <= {sum, prod_q[BW-1:1]};
		end
	end

	assign done    = done_q;
	assign product = prod_q;

endmodule
`default_nettype wire

### hw/rtl/cprpm_serial_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Capture period to rpm: bit-serial divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cprpm_serial_div #(
	parameter int NW = 39,
	parameter int DW = 41
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic [NW-1:0]      quotient
);

	localparam int CntW = (NW > 1) ? $clog2(NW) : 1;

	logic [DW-1:0]   den_q;
	logic [DW-1:0]   rem_q;
	logic [NW-1:0]   quo_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DW:0]     trial;
	logic [DW:0]     diff;

	assign trial = {rem_q, quo_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CntW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			if (!diff[DW]) begin
				rem_q <= diff[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

### hw/rtl/capture_period_to_rpm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Capture period to rpm: top level
// Pairs tachometer capture counts into intervals and converts each interval
// into a speed in 1/16 rpm with a bit-serial multiplier and divider.
// ----------------------------------------------------------------------------
// A capture that completes an interval passes through the serial multiplier
// and then the serial divider before its result word is accepted; the divider
// is skipped when the divisor product is zero. Other words go straight to the
// output register. One word is in flight at a time; the next is accepted while
// the previous result still waits in the output register. Reset clears the
// pending first capture, last speed and output; config takes reset values.
module capture_period_to_rpm #(
	parameter int COUNT_BITS = cprpm_pkg::CountBitsDefault
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	cprpm_stream_if.sink                          capture,
	cprpm_stream_if.source                        result,
	input  wire logic                             cfg_we,
	input  wire logic [cprpm_pkg::CfgIdxW-1:0]    cfg_index,
	input  wire logic [cprpm_pkg::CfgDataW-1:0]   cfg_data
);

	localparam int CountW   = cprpm_pkg::CountW;
	localparam int MaskBits = (COUNT_BITS < CountW) ? COUNT_BITS : CountW;
	localparam logic [CountW:0] MaskFull = ((CountW+1)'(1) << MaskBits) - (CountW+1)'(1);

	typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_EMIT} state_t;

	state_t                               state_q;
	logic [cprpm_pkg::ClockW-1:0]         clock_hz_q;
	logic [cprpm_pkg::PrescW-1:0]         presc_q;
	logic [cprpm_pkg::PeriodW-1:0]        period_q;
	logic [cprpm_pkg::PprW-1:0]           ppr_q;
	logic                                 first_taken_q;
	logic [CountW-1:0]                    first_count_q;
	logic [cprpm_pkg::RpmW-1:0]           last_rpm_q;
	logic                                 done_pend_q;
	logic                                 out_valid_q;
	cprpm_pkg::speed_word_t               out_word_q;

	cprpm_pkg::capture_word_t             cap;
	logic                                 accept;
	logic [CountW-1:0]                    count;
	logic [CountW+1:0]                    ivl_raw;
	logic [cprpm_pkg::IntervalW-1:0]      interval;
	logic [cprpm_pkg::PpW-1:0]            pp;
	logic                                 mul_start;
	logic                                 mul_done;
	logic [cprpm_pkg::DenW-1:0]           den;
	logic                                 div_start;
	logic                                 div_done;
	logic [cprpm_pkg::NumW-1:0]           num;
	logic [cprpm_pkg::NumW-1:0]           quotient;

	assign cap    = capture.payload;
	assign accept = capture.valid && capture.ready;
	assign count  = cap.captured_count & MaskFull[CountW-1:0];

	always_comb begin
		if (count > first_count_q) begin
			ivl_raw = {2'b00, count} - {2'b00, first_count_q};
		end else begin
			ivl_raw = {2'b00, period_q} - {2'b00, first_count_q} + {2'b00, count};
		end
		interval = ivl_raw[CountW+1] ? '0 : ivl_raw[cprpm_pkg::IntervalW-1:0];
	end

	assign pp        = cprpm_pkg::PpW'(presc_q) * cprpm_pkg::PpW'(ppr_q);
	assign mul_start = accept && cap.from_tach_channel && first_taken_q;
	assign num       = {clock_hz_q, 10'b0} - {4'b0, clock_hz_q, 6'b0};
	assign div_start = (state_q == S_MUL) && mul_done && (den != '0);

	cprpm_serial_mul #(
		.AW(cprpm_pkg::PpW),
		.BW(cprpm_pkg::IntervalW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (pp),
		.b      (interval),
		.done   (mul_done),
		.product(den)
	);

	cprpm_serial_div #(
		.NW(cprpm_pkg::NumW),
		.DW(cprpm_pkg::DenW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num     (num),
		.den     (den),
		.done    (div_done),
		.quotient(quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= cprpm_pkg::ClockHzReset;
			presc_q    <= cprpm_pkg::PrescReset;
			period_q   <= cprpm_pkg::PeriodReset;
			ppr_q      <= cprpm_pkg::PprReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cprpm_pkg::REG_CLOCK_HZ:       clock_hz_q <= cfg_data;
				cprpm_pkg::REG_PRESCALER:      presc_q <= cfg_data[cprpm_pkg::PrescW-1:0];
				cprpm_pkg::REG_TIMER_PERIOD:   period_q <= cfg_data[cprpm_pkg::PeriodW-1:0];
				cprpm_pkg::REG_PULSES_PER_REV: ppr_q <= cfg_data[cprpm_pkg::PprW-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			first_taken_q <= 1'b0;
			first_count_q <= '0;
			last_rpm_q    <= '0;
			done_pend_q   <= 1'b0;
			out_valid_q   <= 1'b0;
			out_word_q    <= '0;
		end else begin
			if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						done_pend_q <= 1'b0;
						if (!cap.from_tach_channel) begin
							state_q <= S_EMIT;
						end else if (!first_taken_q) begin
							first_count_q <= count;
							first_taken_q <= 1'b1;
							state_q       <= S_EMIT;
						end else begin
							first_taken_q <= 1'b0;
							state_q       <= S_MUL;
						end
					end
				end
				S_MUL: begin
					if (mul_done) begin
						if (den == '0) begin
							last_rpm_q  <= cprpm_pkg::RpmMax;
							done_pend_q <= 1'b1;
							state_q     <= S_EMIT;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (quotient[cprpm_pkg::NumW-1:cprpm_pkg::RpmW] != '0) begin
							last_rpm_q <= cprpm_pkg::RpmMax;
						end else begin
							last_rpm_q <= quotient[cprpm_pkg::RpmW-1:0];
						end
						done_pend_q <= 1'b1;
						state_q     <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q                 <= 1'b1;
						out_word_q.measurement_done <= done_pend_q;
						out_word_q.rpm_x16          <= last_rpm_q;
						state_q                     <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign capture.ready  = (state_q == S_IDLE);
	assign result.valid   = out_valid_q;
	assign result.payload = out_word_q;

endmodule
`default_nettype wire
